// ===== rtl/prs_pkg.sv =====
// Shared types and constants of the per-class return statistics block.
// Depends on nothing; imported by the controller, the datapath and the top level.
package prs_pkg;

   localparam int NUM_CLASSES_DEF = 8;
   localparam int COUNT_BITS_DEF  = 32;

   localparam int CLASS_BITS = 3;
   localparam int TIME_BITS  = 63;
   localparam int RET_BITS   = 32;
   localparam int CR_BITS    = 48;
   localparam int REQ_BYTES_BITS = 96;
   localparam int RSP_BYTES_BITS = 208;

   // one year in microseconds and 1.0 in Q16.48
   localparam logic [63:0] YEAR_US = 64'd31557600000000;
   localparam logic [63:0] ONE_Q48 = 64'h0001_0000_0000_0000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_UPD, ST_MUL_SQ, ST_MUL_EQ, ST_DIV_DD,
      ST_FIRST, ST_SCAN, ST_NEXT, ST_MEAN, ST_SHARE, ST_SMSQ, ST_CORR,
      ST_VAR, ST_VAR_CHK, ST_MM, ST_A, ST_AY, ST_B, ST_BN, ST_SQRT,
      ST_ZERO, ST_EMIT
   } prs_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_UPD, OP_MUL_SQ, OP_MUL_EQ, OP_DIV_DD, OP_FIRST, OP_NEXT,
      OP_MEAN, OP_SHARE, OP_SMSQ, OP_CORR, OP_VAR, OP_MM, OP_A, OP_AY,
      OP_B, OP_BN, OP_SQRT, OP_ZERO, OP_EMIT
   } prs_op_type;

   typedef struct packed {
      logic       load;
      logic       start;
      prs_op_type op;
   } prs_cmd_type;

   typedef struct packed {
      logic in_range;
      logic unit_done;
      logic class_seen;
      logic sharpe_skip;
      logic var_zero;
      logic idx_last;
      logic out_free;
   } prs_status_type;

endpackage

// ===== rtl/per_class_return_statistics_core.sv =====
// Per-class return statistics: each item (timestamp, class, Q2.30 return) updates
// that class's sums, compounded equity, peak, worst drawdown, count and time, then
// one result per class seen so far comes out in ascending class order, the last
// one flagged on tlast. The update and the report of each class with data run on
// the shared units: the one-bit-per-cycle divider (one division in the update, up
// to six per class in the report), the 64x64 multiplier and the square root. A
// new item is taken once the previous one's last result sits in the output register.
// Uses prs_pkg, prs_controller and prs_datapath.
module per_class_return_statistics_core #(
   parameter int NUM_CLASSES = prs_pkg::NUM_CLASSES_DEF,
   parameter int COUNT_BITS  = prs_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // time_us [62:0], period_return [94:63], zero [95]
   input  logic [prs_pkg::REQ_BYTES_BITS-1:0]   req_tdata,
   // regime_index [2:0]
   input  logic [prs_pkg::CLASS_BITS-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // sample_count [31:0], compound_return [79:32], mean_return [111:80],
   // sharpe_value [143:112], worst_drawdown [175:144], time_share [207:176]
   output logic [prs_pkg::RSP_BYTES_BITS-1:0]   rsp_tdata,
   // class_index [2:0]
   output logic [prs_pkg::CLASS_BITS-1:0]       rsp_tuser,
   output logic                                 rsp_tlast
);
   import prs_pkg::*;

   prs_cmd_type         cmd;
   prs_status_type      status;
   logic [31:0]         sample_count;
   logic signed [47:0]  compound_return;
   logic signed [31:0]  mean_return;
   logic signed [31:0]  sharpe_value;
   logic [31:0]         worst_drawdown;
   logic [31:0]         time_share;

   prs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .cmd       (cmd),
      .status    (status)
   );

   prs_datapath #(
      .NUM_CLASSES (NUM_CLASSES),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .time_us         (req_tdata[62:0]),
      .regime_index    (req_tuser),
      .period_return   ($signed(req_tdata[94:63])),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .class_index     (rsp_tuser),
      .sample_count    (sample_count),
      .compound_return (compound_return),
      .mean_return     (mean_return),
      .sharpe_value    (sharpe_value),
      .worst_drawdown  (worst_drawdown),
      .time_share      (time_share),
      .last_of_run     (rsp_tlast)
   );

   assign rsp_tdata = {time_share, worst_drawdown, sharpe_value, mean_return,
                       compound_return, sample_count};

endmodule

// ===== rtl/prs_divider.sv =====
// Iterative 128 by 64 bit unsigned divider, one quotient bit per cycle.
// Saturates to all ones on a zero divisor or a quotient overflow. No dependencies.
module prs_divider (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] num,
   input  logic [63:0]  den,
   output logic         busy,
   output logic         done,
   output logic [63:0]  quot
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] rem_ff;
   logic [63:0] lo_ff;
   logic [63:0] q_ff;
   logic [63:0] den_ff;

   logic [64:0] shifted;
   logic        take;
   logic [63:0] rem_in;

   // restoring step
   always_comb begin
      shifted = {rem_ff, lo_ff[63]};
      take    = shifted[64] || (shifted[63:0] >= den_ff);
      rem_in  = take ? (shifted[63:0] - den_ff) : shifted[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if ((den == 64'd0) || (num[127:64] >= den)) begin
               q_ff    <= '1;
               done_ff <= 1'b1;
            end else begin
               rem_ff  <= num[127:64];
               lo_ff   <= num[63:0];
               den_ff  <= den;
               cnt_ff  <= '0;
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            lo_ff  <= {lo_ff[62:0], 1'b0};
            q_ff   <= {q_ff[62:0], take};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== rtl/prs_sqrt.sv =====
// Iterative 64 bit integer square root, two radicand bits per cycle.
// Floor of the root after 32 steps. No dependencies.
module prs_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] x_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;

   logic [63:0] trial;
   logic        fits;

   always_comb begin
      trial = res_ff + bit_ff;
      fits  = (x_ff >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            x_ff    <= radicand;
            res_ff  <= '0;
            bit_ff  <= 64'h4000_0000_0000_0000;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (fits) begin
               x_ff   <= x_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

// ===== rtl/prs_datapath.sv =====
// Datapath: per-class state, a 64x64 multiplier built on one 32x32 product,
// the shared divider and square root unit, and the result register. Uses prs_pkg,
// prs_divider and prs_sqrt.
module prs_datapath #(
   parameter int NUM_CLASSES = prs_pkg::NUM_CLASSES_DEF,
   parameter int COUNT_BITS  = prs_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  prs_pkg::prs_cmd_type              cmd,
   output prs_pkg::prs_status_type           status,
   input  logic [prs_pkg::TIME_BITS-1:0]     time_us,
   input  logic [prs_pkg::CLASS_BITS-1:0]    regime_index,
   input  logic signed [prs_pkg::RET_BITS-1:0] period_return,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [prs_pkg::CLASS_BITS-1:0]    class_index,
   output logic [31:0]                       sample_count,
   output logic signed [prs_pkg::CR_BITS-1:0] compound_return,
   output logic signed [31:0]                mean_return,
   output logic signed [31:0]                sharpe_value,
   output logic [31:0]                       worst_drawdown,
   output logic [31:0]                       time_share,
   output logic                              last_of_run
);
   import prs_pkg::*;

   localparam int NUM_USED = (NUM_CLASSES < 8) ? NUM_CLASSES : 8;
   localparam int IDX_BITS = $clog2(NUM_USED);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [31:0] clamp31(input logic [63:0] q);
      return (q > 64'h8000_0000) ? 32'h8000_0000 : q[31:0];
   endfunction

   // per-class state
   logic signed [47:0]    return_sum_ff  [NUM_USED];
   logic [63:0]           square_sum_ff  [NUM_USED];
   logic [63:0]           equity_ff      [NUM_USED];
   logic [63:0]           peak_ff        [NUM_USED];
   logic [31:0]           max_drop_ff    [NUM_USED];
   logic [COUNT_BITS-1:0] class_count_ff [NUM_USED];
   logic [63:0]           class_time_ff  [NUM_USED];
   logic [COUNT_BITS-1:0] total_count_ff;
   logic [63:0]           total_time_ff;
   logic [63:0]           prev_time_ff;
   logic                  have_prev_ff;

   // captured item and working registers
   logic [TIME_BITS-1:0]  now_ff;
   logic [CLASS_BITS-1:0] reg_ff;
   logic signed [31:0]    ret_ff;
   logic [IDX_BITS-1:0]   idx_ff;
   logic signed [31:0]    mean_ff;
   logic [31:0]           share_ff;
   logic [63:0]           corr_ff;
   logic [63:0]           var_ff;
   logic [63:0]           a_ff;
   logic [63:0]           b_ff;
   logic signed [31:0]    sharpe_ff;

   // multiplier
   logic [63:0]  ma_ff;
   logic [63:0]  mb_ff;
   logic [2:0]   ph_ff;
   logic [63:0]  prod_ff;
   logic [127:0] acc_ff;
   logic         mul_busy_ff;
   logic         mul_done_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [CLASS_BITS-1:0]  rsp_class_ff;
   logic [31:0]            rsp_count_ff;
   logic signed [47:0]     rsp_cr_ff;
   logic signed [31:0]     rsp_mean_ff;
   logic signed [31:0]     rsp_sharpe_ff;
   logic [31:0]            rsp_dd_ff;
   logic [31:0]            rsp_share_ff;
   logic                   rsp_last_ff;

   // current entry and derived values
   logic signed [47:0]    cur_sum;
   logic [63:0]           cur_sq;
   logic [63:0]           cur_eq;
   logic [63:0]           cur_peak;
   logic [31:0]           cur_dd;
   logic [COUNT_BITS-1:0] cur_count;
   logic [63:0]           cur_time;
   logic [63:0]           n64;
   logic [31:0]           ret_abs;
   logic [47:0]           sum_abs;
   logic [31:0]           mean_abs;
   logic signed [33:0]    factor;
   logic                  factor_pos;
   logic signed [48:0]    sum_wide;
   logic signed [47:0]    sum_sat;
   logic [63:0]           gap;
   logic [63:0]           eq_new;
   logic [63:0]           peak_new;
   logic [31:0]           dd_new;
   logic [31:0]           mean_new;
   logic [31:0]           sharpe_new;
   logic [63:0]           var_num;
   logic signed [48:0]    cr_wide;
   logic [47:0]           cr_out;
   logic [NUM_USED-1:0]   seen_vec;
   logic                  higher_seen;
   logic                  out_free;
   logic                  rsp_load;
   logic [127:0]          acc_term;

   // unit control
   logic         mul_start;
   logic [63:0]  mul_a;
   logic [63:0]  mul_b;
   logic         div_start;
   logic [127:0] div_num;
   logic [63:0]  div_den;
   logic         div_busy;
   logic         div_done;
   logic [63:0]  div_quot;
   logic         sqrt_start;
   logic [63:0]  sqrt_rad;
   logic         sqrt_busy;
   logic         sqrt_done;
   logic [31:0]  sqrt_root;

   // reads of the selected class
   always_comb begin
      cur_sum   = return_sum_ff[idx_ff];
      cur_sq    = square_sum_ff[idx_ff];
      cur_eq    = equity_ff[idx_ff];
      cur_peak  = peak_ff[idx_ff];
      cur_dd    = max_drop_ff[idx_ff];
      cur_count = class_count_ff[idx_ff];
      cur_time  = class_time_ff[idx_ff];
      n64       = 64'(cur_count);
      ret_abs   = ret_ff[31] ? 32'(-ret_ff) : 32'(ret_ff);
      sum_abs   = cur_sum[47] ? 48'(-cur_sum) : 48'(cur_sum);
      mean_abs  = mean_ff[31] ? 32'(-mean_ff) : 32'(mean_ff);
      factor    = 34'sh4000_0000 + 34'(ret_ff);
      factor_pos = !factor[33] && (factor != 34'sd0);
   end

   // update arithmetic
   always_comb begin
      sum_wide = 49'(cur_sum) + 49'(ret_ff);
      if (sum_wide[48] != sum_wide[47]) begin
         sum_sat = sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         sum_sat = sum_wide[47:0];
      end
      gap = ({1'b0, now_ff} > prev_time_ff) ? ({1'b0, now_ff} - prev_time_ff) : 64'd0;
      if (!factor_pos) begin
         eq_new = '0;
      end else if (acc_ff[127:94] != '0) begin
         eq_new = '1;
      end else begin
         eq_new = acc_ff[93:30];
      end
      peak_new = (eq_new > cur_peak) ? eq_new : cur_peak;
      dd_new   = clamp31(div_quot);
   end

   // report arithmetic
   always_comb begin
      if (cur_sum[47]) begin
         mean_new = (div_quot > 64'h8000_0000) ? 32'h8000_0000 : (~div_quot[31:0] + 32'd1);
      end else begin
         mean_new = (div_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quot[31:0];
      end
      if (!mean_ff[31]) begin
         sharpe_new = (sqrt_root > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : sqrt_root;
      end else begin
         sharpe_new = (sqrt_root > 32'h8000_0000) ? 32'h8000_0000 : (~sqrt_root + 32'd1);
      end
      var_num = (cur_sq > corr_ff) ? (cur_sq - corr_ff) : 64'd0;
      cr_wide = $signed({1'b0, cur_eq[63:16]}) - 49'sd4294967296;
      cr_out  = (!cr_wide[48] && cr_wide[47]) ? {1'b0, {47{1'b1}}} : cr_wide[47:0];
      for (int c = 0; c < NUM_USED; c++) begin
         seen_vec[c] = (class_count_ff[c] != '0);
      end
      higher_seen = 1'b0;
      for (int c = 0; c < NUM_USED; c++) begin
         if ((c > int'(idx_ff)) && seen_vec[c]) begin
            higher_seen = 1'b1;
         end
      end
   end

   // operand selection for the shared units
   always_comb begin
      mul_start  = 1'b0;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      div_num    = '0;
      div_den    = '0;
      sqrt_rad   = (acc_ff[127:64] != '0) ? '1 : acc_ff[63:0];
      case (cmd.op)
         OP_MUL_SQ: begin
            mul_start = cmd.start;
            mul_a     = 64'(ret_abs);
            mul_b     = 64'(ret_abs);
         end
         OP_MUL_EQ: begin
            mul_start = cmd.start;
            mul_a     = cur_eq;
            mul_b     = {32'd0, factor[31:0]};
         end
         OP_SMSQ: begin
            mul_start = cmd.start;
            mul_a     = 64'(sum_abs);
            mul_b     = 64'(sum_abs);
         end
         OP_MM: begin
            mul_start = cmd.start;
            mul_a     = 64'(mean_abs);
            mul_b     = 64'(mean_abs);
         end
         OP_AY: begin
            mul_start = cmd.start;
            mul_a     = a_ff;
            mul_b     = YEAR_US;
         end
         OP_BN: begin
            mul_start = cmd.start;
            mul_a     = b_ff;
            mul_b     = n64;
         end
         OP_DIV_DD: begin
            div_start = cmd.start;
            div_num   = {33'd0, cur_peak - cur_eq, 31'd0};
            div_den   = cur_peak;
         end
         OP_MEAN: begin
            div_start = cmd.start;
            div_num   = {80'd0, sum_abs};
            div_den   = n64;
         end
         OP_SHARE: begin
            div_start = cmd.start;
            div_num   = {33'd0, cur_time, 31'd0};
            div_den   = total_time_ff;
         end
         OP_CORR: begin
            div_start = cmd.start;
            div_num   = {30'd0, acc_ff[127:30]};
            div_den   = n64;
         end
         OP_VAR: begin
            div_start = cmd.start;
            div_num   = {64'd0, var_num};
            div_den   = n64 - 64'd1;
         end
         OP_A: begin
            div_start = cmd.start;
            div_num   = {acc_ff[125:0], 2'b00};
            div_den   = var_ff;
         end
         OP_B: begin
            div_start = cmd.start;
            div_num   = acc_ff;
            div_den   = cur_time;
         end
         OP_SQRT: begin
            sqrt_start = cmd.start;
         end
         default: begin
         end
      endcase
   end

   prs_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   prs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .busy     (sqrt_busy),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // partial product alignment: lo*lo, then the two cross terms, then hi*hi
   always_comb begin
      case (ph_ff)
         3'd1:      acc_term = {64'd0, prod_ff};
         3'd2,
         3'd3:      acc_term = {32'd0, prod_ff, 32'd0};
         3'd4:      acc_term = {prod_ff, 64'd0};
         default:   acc_term = '0;
      endcase
   end

   // 64x64 multiplier over the four 32x32 partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
         mul_done_ff <= 1'b0;
         ph_ff       <= '0;
      end else begin
         mul_done_ff <= 1'b0;
         if (mul_start) begin
            ma_ff       <= mul_a;
            mb_ff       <= mul_b;
            acc_ff      <= '0;
            ph_ff       <= '0;
            mul_busy_ff <= 1'b1;
         end else if (mul_busy_ff) begin
            if (ph_ff < 3'd4) begin
               prod_ff <= (ph_ff[1] ? ma_ff[63:32] : ma_ff[31:0]) *
                          (ph_ff[0] ? mb_ff[63:32] : mb_ff[31:0]);
            end
            acc_ff <= acc_ff + acc_term;
            ph_ff  <= ph_ff + 3'd1;
            if (ph_ff == 3'd4) begin
               mul_busy_ff <= 1'b0;
               mul_done_ff <= 1'b1;
            end
         end
      end
   end

   // per-class and global state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_USED; c++) begin
            return_sum_ff[c]  <= '0;
            square_sum_ff[c]  <= '0;
            equity_ff[c]      <= ONE_Q48;
            peak_ff[c]        <= ONE_Q48;
            max_drop_ff[c]    <= '0;
            class_count_ff[c] <= '0;
            class_time_ff[c]  <= '0;
         end
         total_count_ff <= '0;
         total_time_ff  <= '0;
         prev_time_ff   <= '0;
         have_prev_ff   <= 1'b0;
      end else begin
         case (cmd.op)
            OP_UPD: begin
               return_sum_ff[idx_ff]  <= sum_sat;
               class_count_ff[idx_ff] <= (cur_count == COUNT_MAX) ? cur_count :
                                         cur_count + 1'b1;
               total_count_ff <= (total_count_ff == COUNT_MAX) ? total_count_ff :
                                 total_count_ff + 1'b1;
               if (have_prev_ff) begin
                  class_time_ff[idx_ff] <= sat_add64(cur_time, gap);
                  total_time_ff         <= sat_add64(total_time_ff, gap);
               end
               prev_time_ff <= {1'b0, now_ff};
               have_prev_ff <= 1'b1;
            end
            OP_MUL_SQ: begin
               if (mul_done_ff) begin
                  square_sum_ff[idx_ff] <= sat_add64(cur_sq, {30'd0, acc_ff[63:30]});
               end
            end
            OP_MUL_EQ: begin
               if (mul_done_ff) begin
                  equity_ff[idx_ff] <= eq_new;
                  peak_ff[idx_ff]   <= peak_new;
               end
            end
            OP_DIV_DD: begin
               if (div_done && (cur_peak != 64'd0) && (dd_new > cur_dd)) begin
                  max_drop_ff[idx_ff] <= dd_new;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // captured item, index and working results
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         if (cmd.load) begin
            now_ff <= time_us;
            reg_ff <= regime_index;
            ret_ff <= period_return;
            idx_ff <= regime_index[IDX_BITS-1:0];
         end
         case (cmd.op)
            OP_FIRST: idx_ff <= '0;
            OP_NEXT:  idx_ff <= idx_ff + 1'b1;
            OP_MEAN:  if (div_done) mean_ff <= mean_new;
            OP_SHARE: if (div_done) share_ff <= (total_time_ff == 64'd0) ? 32'd0 :
                                                clamp31(div_quot);
            OP_CORR:  if (div_done) corr_ff <= div_quot;
            OP_VAR:   if (div_done) var_ff <= div_quot;
            OP_A:     if (div_done) a_ff <= div_quot;
            OP_B:     if (div_done) b_ff <= div_quot;
            OP_SQRT:  if (sqrt_done) sharpe_ff <= sharpe_new;
            OP_ZERO:  sharpe_ff <= '0;
            default: begin
            end
         endcase
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = (cmd.op == OP_EMIT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_class_ff  <= CLASS_BITS'(idx_ff);
            rsp_count_ff  <= (n64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n64[31:0];
            rsp_cr_ff     <= cr_out;
            rsp_mean_ff   <= mean_ff;
            rsp_sharpe_ff <= sharpe_ff;
            rsp_dd_ff     <= cur_dd;
            rsp_share_ff  <= share_ff;
            rsp_last_ff   <= !higher_seen;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign class_index     = rsp_class_ff;
   assign sample_count    = rsp_count_ff;
   assign compound_return = rsp_cr_ff;
   assign mean_return     = rsp_mean_ff;
   assign sharpe_value    = rsp_sharpe_ff;
   assign worst_drawdown  = rsp_dd_ff;
   assign time_share      = rsp_share_ff;
   assign last_of_run     = rsp_last_ff;

   // status to the controller
   always_comb begin
      status.in_range    = ({1'b0, reg_ff} < 4'(NUM_USED));
      status.unit_done   = mul_done_ff || div_done || sqrt_done;
      status.class_seen  = (cur_count != '0);
      status.sharpe_skip = (cur_count < 2) || (cur_time == 64'd0) || (mean_ff == 32'sd0);
      status.var_zero    = (var_ff == 64'd0);
      status.idx_last    = (idx_ff == IDX_BITS'(NUM_USED - 1));
      status.out_free    = out_free;
   end

   // only one shared unit finishes at a time
   a_one_done: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_done_ff, div_done, sqrt_done}))
      else $error("more than one arithmetic unit finished in the same cycle");

   // a unit is started only while all units are idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (mul_start || div_start || sqrt_start) |-> (!mul_busy_ff && !div_busy && !sqrt_busy))
      else $error("arithmetic unit started while another is busy");

   // a nonzero Sharpe value needs at least two samples
   a_sharpe_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (sharpe_ff != 32'sd0)) |-> (cur_count > 1))
      else $error("nonzero Sharpe value reported with fewer than two samples");

   // time share never exceeds one
   a_share_range: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_share_ff <= 32'h8000_0000))
      else $error("time share above one");

endmodule

// ===== rtl/prs_controller.sv =====
// Sequencer of the statistics block: steps the datapath through the update of
// one class and the report of every seen class. Uses prs_pkg.
module prs_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output prs_pkg::prs_cmd_type    cmd,
   input  prs_pkg::prs_status_type status
);
   import prs_pkg::*;

   prs_state_type state_ff;
   prs_state_type state_in;
   logic          issued_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= (state_in == state_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: state_in = status.in_range ? ST_UPD : ST_FIRST;
         ST_UPD:      state_in = ST_MUL_SQ;
         ST_MUL_SQ:   if (status.unit_done) state_in = ST_MUL_EQ;
         ST_MUL_EQ:   if (status.unit_done) state_in = ST_DIV_DD;
         ST_DIV_DD:   if (status.unit_done) state_in = ST_FIRST;
         ST_FIRST:    state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.class_seen) begin
               state_in = ST_MEAN;
            end else begin
               state_in = status.idx_last ? ST_IDLE : ST_NEXT;
            end
         end
         ST_NEXT:     state_in = ST_SCAN;
         ST_MEAN:     if (status.unit_done) state_in = ST_SHARE;
         ST_SHARE: begin
            if (status.unit_done) begin
               state_in = status.sharpe_skip ? ST_ZERO : ST_SMSQ;
            end
         end
         ST_SMSQ:     if (status.unit_done) state_in = ST_CORR;
         ST_CORR:     if (status.unit_done) state_in = ST_VAR;
         ST_VAR:      if (status.unit_done) state_in = ST_VAR_CHK;
         ST_VAR_CHK:  state_in = status.var_zero ? ST_ZERO : ST_MM;
         ST_MM:       if (status.unit_done) state_in = ST_A;
         ST_A:        if (status.unit_done) state_in = ST_AY;
         ST_AY:       if (status.unit_done) state_in = ST_B;
         ST_B:        if (status.unit_done) state_in = ST_BN;
         ST_BN:       if (status.unit_done) state_in = ST_SQRT;
         ST_SQRT:     if (status.unit_done) state_in = ST_EMIT;
         ST_ZERO:     state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.idx_last ? ST_IDLE : ST_NEXT;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      cmd.load  = req_valid && (state_ff == ST_IDLE);
      cmd.start = !issued_ff;
      unique case (state_ff)
         ST_UPD:    cmd.op = OP_UPD;
         ST_MUL_SQ: cmd.op = OP_MUL_SQ;
         ST_MUL_EQ: cmd.op = OP_MUL_EQ;
         ST_DIV_DD: cmd.op = OP_DIV_DD;
         ST_FIRST:  cmd.op = OP_FIRST;
         ST_NEXT:   cmd.op = OP_NEXT;
         ST_MEAN:   cmd.op = OP_MEAN;
         ST_SHARE:  cmd.op = OP_SHARE;
         ST_SMSQ:   cmd.op = OP_SMSQ;
         ST_CORR:   cmd.op = OP_CORR;
         ST_VAR:    cmd.op = OP_VAR;
         ST_MM:     cmd.op = OP_MM;
         ST_A:      cmd.op = OP_A;
         ST_AY:     cmd.op = OP_AY;
         ST_B:      cmd.op = OP_B;
         ST_BN:     cmd.op = OP_BN;
         ST_SQRT:   cmd.op = OP_SQRT;
         ST_ZERO:   cmd.op = OP_ZERO;
         ST_EMIT:   cmd.op = OP_EMIT;
         default:   cmd.op = OP_NONE;
      endcase
   end

endmodule
